// ----- hdl/dmds_pkg.sv -----
`timescale 1ns / 1ps

package dmds_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_SPIN_LEFT  = 2'd0,
    DIR_SPIN_RIGHT = 2'd1,
    DIR_AHEAD      = 2'd2,
    DIR_ASTERN     = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_LQ   = 3'd2,
    PH_RH   = 3'd3,
    PH_LH   = 3'd4,
    PH_RQ   = 3'd5,
    PH_STOP = 3'd6
  } phase_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TICKS    = 3'd4;

  localparam logic [14:0] MAX_SPEED_RST     = 15'd1000;
  localparam logic [14:0] SWEEP_SPEED_RST   = 15'd250;
  localparam logic [15:0] WAIT_TICKS_RST    = 16'd1000;
  localparam logic [15:0] QUARTER_TICKS_RST = 16'd500;
  localparam logic [15:0] HALF_TICKS_RST    = 16'd1000;

  localparam logic [2:0] TURNS_MAX = 3'd7;
  localparam logic [2:0] TURNS_END = 3'd4;

  typedef struct packed {
    logic [14:0] duty;
    logic        fwd;
    logic        rev;
  } drive_t;

  localparam drive_t DRIVE_OFF = '{duty: 15'd0, fwd: 1'b0, rev: 1'b0};

  // clamp to +/- lim, split into magnitude and direction pins
  function automatic drive_t drive_set(input logic signed [16:0] s, input logic [14:0] lim);
    logic signed [17:0] sx;
    logic signed [17:0] lx;
    logic signed [17:0] c;
    logic signed [17:0] mag;
    drive_t d;
    sx = {s[16], s};
    lx = {3'b000, lim};
    if (sx > lx) begin
      c = lx;
    end else if (sx < -lx) begin
      c = -lx;
    end else begin
      c = sx;
    end
    mag = c[17] ? -c : c;
    d.duty = mag[14:0];
    d.fwd  = (c > 18'sd0);
    d.rev  = c[17];
    return d;
  endfunction

endpackage

// ----- hdl/dual_motor_drive_sweep_sequencer.sv -----
`timescale 1ns / 1ps

// channel | direction | handshake           | payload
// in_     | input     | in_valid/in_ready   | cmd, dir, speed, duration
// out_    | output    | out_valid/out_ready | drives, pins, enable, sweep_done, phase
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transfer per cycle while in_ready is high; the result follows in the next cycle.
// All state updates in one pass of clamp and 32-bit compare logic before the registers.
// in_ready is high while the result register is empty or being taken this cycle.
// cfg_ready is always high. Reset is synchronous, active low; no clearing pass.
module dual_motor_drive_sweep_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_cmd,
  input  logic [1:0]                     in_dir,
  input  logic signed [15:0]             in_speed,
  input  logic [31:0]                    in_duration,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [14:0]                    out_left_duty,
  output logic                           out_left_forward,
  output logic                           out_left_reverse,
  output logic [14:0]                    out_right_duty,
  output logic                           out_right_forward,
  output logic                           out_right_reverse,
  output logic                           out_driver_enable,
  output logic                           out_sweep_done,
  output logic [2:0]                     out_sweep_phase,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import dmds_pkg::*;

  logic [14:0] max_speed_r;
  logic [14:0] sweep_speed_r;
  logic [15:0] wait_ticks_r;
  logic [15:0] quarter_ticks_r;
  logic [15:0] half_ticks_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  turns_r, turns_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] phase_len_r, phase_len_nxt;
  drive_t      left_r, left_nxt;
  drive_t      right_r, right_nxt;
  logic        driver_on_r, driver_on_nxt;
  logic        armed_r, armed_nxt;
  logic        done_r, done_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic               in_xfer;
  logic [31:0]        elapsed_inc;
  logic               due;
  logic [2:0]         turns_inc;
  logic               mv_en;
  logic               stop_en;
  dir_t               mv_dir;
  logic signed [16:0] mv_spd;
  logic signed [16:0] mv_neg;
  logic [31:0]        mv_len;
  logic signed [16:0] sweep_spd;

  assign in_xfer   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign elapsed_inc = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;
  assign due         = (elapsed_inc >= phase_len_r);
  assign turns_inc   = (turns_r < TURNS_MAX) ? turns_r + 3'd1 : turns_r;
  assign sweep_spd   = {2'b00, sweep_speed_r};
  assign mv_neg      = -mv_spd;

  always_comb begin
    phase_nxt     = phase_r;
    turns_nxt     = turns_r;
    elapsed_nxt   = elapsed_r;
    phase_len_nxt = phase_len_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    driver_on_nxt = driver_on_r;
    armed_nxt     = armed_r;
    done_nxt      = 1'b0;
    mv_en         = 1'b0;
    stop_en       = 1'b0;
    mv_dir        = dir_t'(in_dir);
    mv_spd        = {in_speed[15], in_speed};
    mv_len        = in_duration;

    case (cmd_t'(in_cmd))
      CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        case (phase_r)
          PH_WAIT: begin
            if (due) begin
              phase_nxt = PH_LQ;
              mv_en     = 1'b1;
              mv_dir    = DIR_SPIN_LEFT;
              mv_spd    = sweep_spd;
              mv_len    = {16'd0, quarter_ticks_r};
            end
          end
          PH_LQ: begin
            if (due) begin
              turns_nxt = turns_inc;
              if (turns_inc >= TURNS_END) begin
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = PH_RH;
                mv_en     = 1'b1;
                mv_dir    = DIR_SPIN_RIGHT;
                mv_spd    = sweep_spd;
                mv_len    = {16'd0, half_ticks_r};
              end
            end
          end
          PH_RH: begin
            if (due) begin
              turns_nxt = turns_inc;
              if (turns_inc >= TURNS_END) begin
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = PH_LH;
                mv_en     = 1'b1;
                mv_dir    = DIR_SPIN_LEFT;
                mv_spd    = sweep_spd;
                mv_len    = {16'd0, half_ticks_r};
              end
            end
          end
          PH_LH: begin
            if (due) begin
              turns_nxt = turns_inc;
              if (turns_inc >= TURNS_END) begin
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = PH_RQ;
                mv_en     = 1'b1;
                mv_dir    = DIR_SPIN_RIGHT;
                mv_spd    = sweep_spd;
                mv_len    = {16'd0, quarter_ticks_r};
              end
            end
          end
          PH_RQ: begin
            if (due) begin
              turns_nxt = turns_inc;
              phase_nxt = PH_STOP;
            end
          end
          PH_STOP: begin
            stop_en = 1'b1;
          end
          default: begin
          end
        endcase
      end
      CMD_MOVE: begin
        mv_en = 1'b1;
      end
      CMD_START: begin
        armed_nxt     = 1'b1;
        turns_nxt     = 3'd0;
        phase_nxt     = PH_WAIT;
        phase_len_nxt = {16'd0, wait_ticks_r};
        elapsed_nxt   = 32'd0;
      end
      default: begin
        stop_en = 1'b1;
      end
    endcase

    if (mv_en) begin
      case (mv_dir)
        DIR_SPIN_LEFT: begin
          left_nxt  = drive_set(mv_neg, max_speed_r);
          right_nxt = drive_set(mv_spd, max_speed_r);
        end
        DIR_SPIN_RIGHT: begin
          left_nxt  = drive_set(mv_spd, max_speed_r);
          right_nxt = drive_set(mv_neg, max_speed_r);
        end
        DIR_AHEAD: begin
          left_nxt  = drive_set(mv_spd, max_speed_r);
          right_nxt = drive_set(mv_spd, max_speed_r);
        end
        default: begin
          left_nxt  = drive_set(mv_neg, max_speed_r);
          right_nxt = drive_set(mv_neg, max_speed_r);
        end
      endcase
      elapsed_nxt   = 32'd0;
      phase_len_nxt = mv_len;
      driver_on_nxt = 1'b1;
    end

    if (stop_en) begin
      done_nxt      = armed_r;
      left_nxt      = DRIVE_OFF;
      right_nxt     = DRIVE_OFF;
      driver_on_nxt = 1'b0;
      phase_nxt     = PH_IDLE;
      armed_nxt     = 1'b0;
    end
  end

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      turns_r     <= 3'd0;
      elapsed_r   <= 32'd0;
      phase_len_r <= 32'd0;
      left_r      <= DRIVE_OFF;
      right_r     <= DRIVE_OFF;
      driver_on_r <= 1'b0;
      armed_r     <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        turns_r     <= turns_nxt;
        elapsed_r   <= elapsed_nxt;
        phase_len_r <= phase_len_nxt;
        left_r      <= left_nxt;
        right_r     <= right_nxt;
        driver_on_r <= driver_on_nxt;
        armed_r     <= armed_nxt;
        done_r      <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r     <= MAX_SPEED_RST;
      sweep_speed_r   <= SWEEP_SPEED_RST;
      wait_ticks_r    <= WAIT_TICKS_RST;
      quarter_ticks_r <= QUARTER_TICKS_RST;
      half_ticks_r    <= HALF_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SPEED:     max_speed_r     <= cfg_data[14:0];
        CFG_SWEEP_SPEED:   sweep_speed_r   <= cfg_data[14:0];
        CFG_WAIT_TICKS:    wait_ticks_r    <= cfg_data;
        CFG_QUARTER_TICKS: quarter_ticks_r <= cfg_data;
        CFG_HALF_TICKS:    half_ticks_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_duty     = left_r.duty;
  assign out_left_forward  = left_r.fwd;
  assign out_left_reverse  = left_r.rev;
  assign out_right_duty    = right_r.duty;
  assign out_right_forward = right_r.fwd;
  assign out_right_reverse = right_r.rev;
  assign out_driver_enable = driver_on_r;
  assign out_sweep_done    = done_r;
  assign out_sweep_phase   = phase_r;

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_sweep_done |-> (phase_r == PH_IDLE) && !driver_on_r && !armed_r)
    else $error("sweep_done without idle stop");

  a_pins_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(left_r.fwd && left_r.rev) && !(right_r.fwd && right_r.rev))
    else $error("forward and reverse both set");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !driver_on_r |-> (left_r == DRIVE_OFF) && (right_r == DRIVE_OFF))
    else $error("motor drive active with driver off");

  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_cmd == CMD_TICK) && (phase_r == PH_STOP)
      |=> (phase_r == PH_IDLE) && (done_r == $past(armed_r)))
    else $error("stopping phase did not end");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("transfer without result");
`endif

endmodule
